// ===== rtl/srbag_pkg.sv =====
package srbag_pkg;

    // Field widths
    localparam int CORNER_W  = 12;
    localparam int INDEX_W   = 14;
    localparam int SRC_OFF_W = 26;
    localparam int DST_OFF_W = 28;

    // Register widths and port geometry
    localparam int ORIENT_W  = 2;
    localparam int SCALE_W   = 3;
    localparam int BPP_W     = 3;
    localparam int SPITCH_W  = 14;
    localparam int DPITCH_W  = 16;
    localparam int PANEL_W   = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 1;

    // Internal datapath widths
    localparam int STEP_W  = 17;                    // 1.16 step, at most 1.0
    localparam int SPAN_W  = CORNER_W + SCALE_W;    // scaled span
    localparam int PROD_W  = INDEX_W + STEP_W;      // index times step
    localparam int FIX_W   = 32;                    // 16.16 source coordinate
    localparam int COORD_W = 16;                    // destination x or y

    localparam int MAX_DIM_DEFAULT = 4096;

    // Register reset values
    localparam logic [SCALE_W-1:0] SCALE_RST = 3'd1;
    localparam logic [BPP_W-1:0]   BPP_RST   = 3'd4;
    localparam logic [PANEL_W-1:0] PANEL_RST = 15'd1;

    typedef enum logic [ORIENT_W-1:0] {
        ORIENT_NORMAL = 2'd0,
        ORIENT_CCW    = 2'd1,
        ORIENT_CW     = 2'd2,
        ORIENT_RSVD   = 2'd3
    } orient_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIENT  = 3'd0,
        REG_SCALE   = 3'd1,
        REG_BPP     = 3'd2,
        REG_SPITCH  = 3'd3,
        REG_DPITCH  = 3'd4,
        REG_PANEL_W = 3'd5,
        REG_PANEL_H = 3'd6
    } reg_idx_t;

    // 65536 / scale; the source span cancels out of the step
    function automatic logic [STEP_W-1:0] step_lut(input logic [SCALE_W-1:0] scale);
        logic [STEP_W-1:0] step;
        begin
            unique case (scale)
                3'd1:    step = 17'd65536;
                3'd2:    step = 17'd32768;
                3'd3:    step = 17'd21845;
                3'd4:    step = 17'd16384;
                3'd5:    step = 17'd13107;
                3'd6:    step = 17'd10922;
                3'd7:    step = 17'd9362;
                default: step = 17'd0;
            endcase
            return step;
        end
    endfunction

endpackage

// ===== rtl/scaled_rotated_blit_address_gen_unit.sv =====
// Nearest-neighbour scale and rotate-by-90 blit address generator.
// Configuration is loaded through cfg_wr_en / cfg_index / cfg_wdata; the user must
// load it only while no item is in flight (not enforced by the block). Each
// write lands at the clock edge where cfg_wr_en is high. The input stream carries
// one dirty source rectangle and one destination pixel index per transfer; the
// output stream returns one result per input: copy flag on m_tuser and the source
// and destination byte offsets on m_tdata. An item passes from input transfer to
// m_tvalid through four pipeline stages (corner ordering, step multiply,
// coordinate and mirror, offset multiplies) and the output register that adds the
// offset terms. Throughput is one item per clock unless stalled; each stage holds
// its own valid bit, so the input keeps taking items while some stage downstream
// has room, and a result waiting in the output register holds back only the full
// stages behind it. When the receiver stalls, the result holds on m_tdata/m_tuser
// and the pipe fills up; s_tready drops only once every stage is full.
// Synchronous reset (aresetn low) empties the pipe and loads the register
// defaults: normal orientation, scale 1, 4 bytes per pixel, pitches 0,
// panel size 1. No clearing pass is needed.
module scaled_rotated_blit_address_gen_unit #(
    parameter int MAX_DIM = srbag_pkg::MAX_DIM_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [srbag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srbag_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // rect_x1, rect_y1, rect_x2, rect_y2, col_index, row_index, zero pad
    input  logic [srbag_pkg::S_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // src_offset, dst_offset, zero pad
    output logic [srbag_pkg::M_TDATA_W-1:0]  m_tdata,
    // copy
    output logic [srbag_pkg::M_TUSER_W-1:0]  m_tuser
);
    import srbag_pkg::*;

    localparam int CLAMP_INT = (MAX_DIM > (1 << CORNER_W) - 1) ? (1 << CORNER_W) - 1 : MAX_DIM;
    localparam logic [CORNER_W-1:0] CLAMP_MAX = CORNER_W'(CLAMP_INT);

    // Configuration registers
    orient_t                orientation_reg;
    logic [SCALE_W-1:0]     scale_reg;
    logic [BPP_W-1:0]       bpp_reg;
    logic [SPITCH_W-1:0]    src_pitch_reg;
    logic [DPITCH_W-1:0]    dst_pitch_reg;
    logic [PANEL_W-1:0]     panel_w_reg;
    logic [PANEL_W-1:0]     panel_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orientation_reg <= ORIENT_NORMAL;
            scale_reg       <= SCALE_RST;
            bpp_reg         <= BPP_RST;
            src_pitch_reg   <= '0;
            dst_pitch_reg   <= '0;
            panel_w_reg     <= PANEL_RST;
            panel_h_reg     <= PANEL_RST;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_ORIENT:  orientation_reg <= orient_t'(cfg_wdata[ORIENT_W-1:0]);
                REG_SCALE:   scale_reg       <= cfg_wdata[SCALE_W-1:0];
                REG_BPP:     bpp_reg         <= cfg_wdata[BPP_W-1:0];
                REG_SPITCH:  src_pitch_reg   <= cfg_wdata[SPITCH_W-1:0];
                REG_DPITCH:  dst_pitch_reg   <= cfg_wdata[DPITCH_W-1:0];
                REG_PANEL_W: panel_w_reg     <= cfg_wdata[PANEL_W-1:0];
                REG_PANEL_H: panel_h_reg     <= cfg_wdata[PANEL_W-1:0];
                default:     ;
            endcase
        end
    end

    // Reserved orientation code acts as normal
    orient_t orient_eff;
    assign orient_eff = (orientation_reg == ORIENT_RSVD) ? ORIENT_NORMAL : orientation_reg;

    // Stage handshake: a stage loads when it is empty or its successor loads
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_tvalid_reg;
    logic rdy_out, rdy4, rdy3, rdy2, rdy1;

    assign rdy_out  = !m_tvalid_reg || m_tready;
    assign rdy4     = !v4_reg || rdy_out;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (rdy1)    v1_reg       <= s_tvalid;
            if (rdy2)    v2_reg       <= v1_reg;
            if (rdy3)    v3_reg       <= v2_reg;
            if (rdy4)    v4_reg       <= v3_reg;
            if (rdy_out) m_tvalid_reg <= v4_reg;
        end
    end

    // ---------------- Stage 1: clamp and order corners ----------------
    logic [CORNER_W-1:0] ax, ay, bx, by;
    logic [CORNER_W-1:0] lx_next, ly_next, spx_next, spy_next;
    logic [CORNER_W-1:0] lx1_reg, ly1_reg, spx1_reg, spy1_reg;
    logic [INDEX_W-1:0]  col1_reg, row1_reg;

    always_comb begin
        ax = s_tdata[11:0];
        ay = s_tdata[23:12];
        bx = s_tdata[35:24];
        by = s_tdata[47:36];
        if (ax > CLAMP_MAX) ax = CLAMP_MAX;
        if (ay > CLAMP_MAX) ay = CLAMP_MAX;
        if (bx > CLAMP_MAX) bx = CLAMP_MAX;
        if (by > CLAMP_MAX) by = CLAMP_MAX;
        lx_next  = (ax < bx) ? ax : bx;
        ly_next  = (ay < by) ? ay : by;
        spx_next = (ax < bx) ? (bx - ax) : (ax - bx);
        spy_next = (ay < by) ? (by - ay) : (ay - by);
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            lx1_reg  <= lx_next;
            ly1_reg  <= ly_next;
            spx1_reg <= spx_next;
            spy1_reg <= spy_next;
            col1_reg <= s_tdata[61:48];
            row1_reg <= s_tdata[75:62];
        end
    end

    // ---------------- Stage 2: range check, step multiply, dest coords ----------------
    logic [SPAN_W-1:0]  spanw, spanh;
    logic [STEP_W-1:0]  step;
    logic [PROD_W-1:0]  pu_next, pv_next;
    logic [COORD_W-1:0] px_next, py_next;
    logic               go_next;
    logic [CORNER_W-1:0] lx2_reg, ly2_reg;
    logic [PROD_W-1:0]  pu2_reg, pv2_reg;
    logic [COORD_W-1:0] px2_reg, py2_reg;
    logic               go2_reg;

    always_comb begin
        spanw   = SPAN_W'(spx1_reg) * SPAN_W'(scale_reg);
        spanh   = SPAN_W'(spy1_reg) * SPAN_W'(scale_reg);
        step    = step_lut(scale_reg);
        pu_next = PROD_W'(col1_reg) * PROD_W'(step);
        pv_next = PROD_W'(row1_reg) * PROD_W'(step);
        px_next = COORD_W'(lx1_reg) * COORD_W'(scale_reg) + COORD_W'(col1_reg);
        py_next = COORD_W'(ly1_reg) * COORD_W'(scale_reg) + COORD_W'(row1_reg);
        // drop normal copies at unit scale and indexes outside the rectangle
        go_next = (SPAN_W'(col1_reg) < spanw) && (SPAN_W'(row1_reg) < spanh)
                  && !((orient_eff == ORIENT_NORMAL) && (scale_reg == SCALE_RST));
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            lx2_reg <= lx1_reg;
            ly2_reg <= ly1_reg;
            pu2_reg <= pu_next;
            pv2_reg <= pv_next;
            px2_reg <= px_next;
            py2_reg <= py_next;
            go2_reg <= go_next;
        end
    end

    // ---------------- Stage 3: source coords, mirroring ----------------
    logic [FIX_W-1:0]   fx, fy;
    logic [COORD_W-1:0] row_term_next, col_term_next;
    logic               off_panel;
    logic [COORD_W-1:0] sx3_reg, sy3_reg, row3_reg, col3_reg;
    logic               copy3_reg;

    always_comb begin
        fx = {FIX_W'(lx2_reg)} << 16;
        fy = {FIX_W'(ly2_reg)} << 16;
        fx = fx + FIX_W'(pu2_reg);
        fy = fy + FIX_W'(pv2_reg);
        off_panel = 1'b0;
        unique case (orient_eff)
            ORIENT_CCW: begin
                off_panel     = px2_reg >= COORD_W'(panel_h_reg);
                row_term_next = COORD_W'(panel_h_reg) - COORD_W'(1) - px2_reg;
                col_term_next = py2_reg;
            end
            ORIENT_CW: begin
                off_panel     = py2_reg >= COORD_W'(panel_w_reg);
                row_term_next = px2_reg;
                col_term_next = COORD_W'(panel_w_reg) - COORD_W'(1) - py2_reg;
            end
            default: begin
                row_term_next = py2_reg;
                col_term_next = px2_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            sx3_reg   <= fx[FIX_W-1:16];
            sy3_reg   <= fy[FIX_W-1:16];
            row3_reg  <= row_term_next;
            col3_reg  <= col_term_next;
            copy3_reg <= go2_reg && !off_panel;
        end
    end

    // ---------------- Stage 4: offset term multiplies ----------------
    localparam int SROW_W = COORD_W + SPITCH_W;
    localparam int DROW_W = COORD_W + DPITCH_W;
    localparam int BCOL_W = COORD_W + BPP_W;

    logic [SROW_W-1:0] srow4_reg;
    logic [BCOL_W-1:0] scol4_reg, dcol4_reg;
    logic [DROW_W-1:0] drow4_reg;
    logic              copy4_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            srow4_reg <= SROW_W'(sy3_reg) * SROW_W'(src_pitch_reg);
            scol4_reg <= BCOL_W'(sx3_reg) * BCOL_W'(bpp_reg);
            drow4_reg <= DROW_W'(row3_reg) * DROW_W'(dst_pitch_reg);
            dcol4_reg <= BCOL_W'(col3_reg) * BCOL_W'(bpp_reg);
            copy4_reg <= copy3_reg;
        end
    end

    // ---------------- Output register: add terms, zero on no copy ----------------
    logic [SROW_W-1:0]    soff_sum;
    logic [DROW_W-1:0]    doff_sum;
    logic [SRC_OFF_W-1:0] soff_next;
    logic [DST_OFF_W-1:0] doff_next;
    logic [SRC_OFF_W-1:0] soff_reg;
    logic [DST_OFF_W-1:0] doff_reg;
    logic                 copy_reg;

    always_comb begin
        soff_sum  = srow4_reg + SROW_W'(scol4_reg);
        doff_sum  = drow4_reg + DROW_W'(dcol4_reg);
        soff_next = copy4_reg ? soff_sum[SRC_OFF_W-1:0] : '0;
        doff_next = copy4_reg ? doff_sum[DST_OFF_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (rdy_out) begin
            soff_reg <= soff_next;
            doff_reg <= doff_next;
            copy_reg <= copy4_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - SRC_OFF_W - DST_OFF_W){1'b0}}, doff_reg, soff_reg};
    assign m_tuser  = copy_reg;

endmodule

// ===== rtl/srbag_checker.sv =====
module srbag_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [srbag_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [srbag_pkg::M_TUSER_W-1:0]  m_tuser
);
    import srbag_pkg::*;

    // Reset empties the pipe: no result, input open right after
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipe not empty after reset");

    // A result not taken holds its value
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A dropped pixel carries zero offsets
    a_nocopy_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("offsets not zero on no-copy result");

    // A full pipe with a stalled output stops taking input
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && !s_tready |=> !s_tready || m_tready)
        else $error("input reopened without output transfer");

endmodule

bind scaled_rotated_blit_address_gen_unit srbag_checker u_srbag_checker (.*);

// ===== verif/blit_addr_checker.sv =====
`timescale 1ns / 1ps

// Watch the configuration port and both streams, predict the offsets for every
// input transfer and compare each result transfer against the oldest prediction.
module blit_addr_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [srbag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srbag_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [srbag_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [srbag_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [srbag_pkg::M_TUSER_W-1:0]  m_tuser,
    output int                               fail_count,
    output int                               pending_count
);
    import srbag_pkg::*;

    typedef struct {
        logic                 copy;
        logic [SRC_OFF_W-1:0] src_off;
        logic [DST_OFF_W-1:0] dst_off;
    } blit_offsets_t;

    // shadow copy of the block's registers
    orient_t              orient_q;
    logic [SCALE_W-1:0]   scale_q;
    logic [BPP_W-1:0]     bpp_q;
    logic [SPITCH_W-1:0]  spitch_q;
    logic [DPITCH_W-1:0]  dpitch_q;
    logic [PANEL_W-1:0]   panel_w_q;
    logic [PANEL_W-1:0]   panel_h_q;

    blit_offsets_t expected_blits[$];
    int errors = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // Map one rectangle and destination index to source and destination offsets.
    function automatic blit_offsets_t predict_blit_offsets(input logic [S_TDATA_W-1:0] d);
        logic [63:0] ax, ay, bx, by, col, row;
        logic [63:0] lx, hx, ly, hy, spanw, spanh, du, dv;
        logic [63:0] sx, sy, px, py, soff, doff;
        orient_t       dir;
        blit_offsets_t r;
        r = '{1'b0, '0, '0};
        // 12-bit corners never exceed MAX_DIM, so no saturation is needed
        ax  = d[0 +: CORNER_W];
        ay  = d[CORNER_W +: CORNER_W];
        bx  = d[2*CORNER_W +: CORNER_W];
        by  = d[3*CORNER_W +: CORNER_W];
        col = d[4*CORNER_W +: INDEX_W];
        row = d[4*CORNER_W+INDEX_W +: INDEX_W];
        dir = (orient_q == ORIENT_RSVD) ? ORIENT_NORMAL : orient_q;

        lx = (ax < bx) ? ax : bx;
        hx = (ax < bx) ? bx : ax;
        ly = (ay < by) ? ay : by;
        hy = (ay < by) ? by : ay;

        // plain copy at unit scale moves nothing
        if (dir == ORIENT_NORMAL && scale_q == 1) return r;

        spanw = (hx - lx) * scale_q;
        spanh = (hy - ly) * scale_q;
        if (col >= spanw || row >= spanh) return r;

        // 16.16 stepping through the source
        du   = ((hx - lx) << 16) / spanw;
        dv   = ((hy - ly) << 16) / spanh;
        sx   = ((lx << 16) + col * du) >> 16;
        sy   = ((ly << 16) + row * dv) >> 16;
        soff = sy * spitch_q + sx * bpp_q;

        px = lx * scale_q + col;
        py = ly * scale_q + row;

        case (dir)
            ORIENT_CCW: begin
                if (px >= panel_h_q) return r;
                doff = (panel_h_q - 1 - px) * dpitch_q + py * bpp_q;
            end
            ORIENT_CW: begin
                if (py >= panel_w_q) return r;
                doff = px * dpitch_q + (panel_w_q - 1 - py) * bpp_q;
            end
            default: begin
                doff = py * dpitch_q + px * bpp_q;
            end
        endcase

        r.copy    = 1'b1;
        r.src_off = soff[SRC_OFF_W-1:0];
        r.dst_off = doff[DST_OFF_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        blit_offsets_t        want;
        logic [SRC_OFF_W-1:0] got_src;
        logic [DST_OFF_W-1:0] got_dst;
        if (!aresetn) begin
            orient_q  = ORIENT_NORMAL;
            scale_q   = SCALE_RST;
            bpp_q     = BPP_RST;
            spitch_q  = '0;
            dpitch_q  = '0;
            panel_w_q = PANEL_RST;
            panel_h_q = PANEL_RST;
            expected_blits.delete();
        end else begin
            // track register writes
            if (cfg_wr_en) begin
                case (reg_idx_t'(cfg_index))
                    REG_ORIENT:  orient_q  = orient_t'(cfg_wdata[ORIENT_W-1:0]);
                    REG_SCALE:   scale_q   = cfg_wdata[SCALE_W-1:0];
                    REG_BPP:     bpp_q     = cfg_wdata[BPP_W-1:0];
                    REG_SPITCH:  spitch_q  = cfg_wdata[SPITCH_W-1:0];
                    REG_DPITCH:  dpitch_q  = cfg_wdata[DPITCH_W-1:0];
                    REG_PANEL_W: panel_w_q = cfg_wdata[PANEL_W-1:0];
                    REG_PANEL_H: panel_h_q = cfg_wdata[PANEL_W-1:0];
                    default: ;
                endcase
            end

            // predict on every input transfer
            if (s_tvalid && s_tready)
                expected_blits.push_back(predict_blit_offsets(s_tdata));

            // compare every result transfer with the oldest prediction
            if (m_tvalid && m_tready) begin
                got_src = m_tdata[0 +: SRC_OFF_W];
                got_dst = m_tdata[SRC_OFF_W +: DST_OFF_W];
                if (expected_blits.size() == 0) begin
                    report_mismatch($sformatf("result with none pending: copy %0d src 0x%0h dst 0x%0h",
                                              m_tuser[0], got_src, got_dst));
                end else begin
                    want = expected_blits.pop_front();
                    if (m_tuser[0] !== want.copy)
                        report_mismatch($sformatf("copy got %0d expected %0d",
                                                  m_tuser[0], want.copy));
                    if (got_src !== want.src_off)
                        report_mismatch($sformatf("src_offset got 0x%0h expected 0x%0h",
                                                  got_src, want.src_off));
                    if (got_dst !== want.dst_off)
                        report_mismatch($sformatf("dst_offset got 0x%0h expected 0x%0h",
                                                  got_dst, want.dst_off));
                end
            end
        end
        fail_count    <= errors;
        pending_count <= expected_blits.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import srbag_pkg::*;

    typedef struct {
        orient_t orient;
        int      scale;
        int      bpp;
        int      spitch;
        int      dpitch;
        int      pw;
        int      ph;
        int      corner_lim;   // upper bound on the low corner of shaped rectangles
    } blit_setup_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    int          fail_count;
    int          pending_count;
    int          idle_cycles = 0;
    bit          steady      = 1'b0;
    blit_setup_t cur         = '{ORIENT_NORMAL, 1, 4, 0, 0, 1, 1, 4095};

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    scaled_rotated_blit_address_gen_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    blit_addr_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Stall the result side about 30% of the time, except in the steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 30);
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 2000) begin
            $display("scaled_rotated_blit_address_gen_unit test failed");
            $finish;
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_rect(input int x1, input int y1,
                                                       input int x2, input int y2,
                                                       input int col, input int row);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[0 +: CORNER_W]                = x1[CORNER_W-1:0];
        d[CORNER_W +: CORNER_W]         = y1[CORNER_W-1:0];
        d[2*CORNER_W +: CORNER_W]       = x2[CORNER_W-1:0];
        d[3*CORNER_W +: CORNER_W]       = y2[CORNER_W-1:0];
        d[4*CORNER_W +: INDEX_W]        = col[INDEX_W-1:0];
        d[4*CORNER_W+INDEX_W +: INDEX_W] = row[INDEX_W-1:0];
        return d;
    endfunction

    // Present one item, now and then after a random gap, and hold it until the transfer
    task automatic send_item(input logic [S_TDATA_W-1:0] d);
        if (!steady && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DAT_W-1:0];
    endtask

    task automatic load_setup(input blit_setup_t s);
        write_reg(REG_ORIENT, int'(s.orient));
        write_reg(REG_SCALE, s.scale);
        write_reg(REG_BPP, s.bpp);
        write_reg(REG_SPITCH, s.spitch);
        write_reg(REG_DPITCH, s.dpitch);
        write_reg(REG_PANEL_W, s.pw);
        write_reg(REG_PANEL_H, s.ph);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur = s;
    endtask

    // Corner cases under the current setup: empty and reversed rectangles,
    // indices at and past the span, field extremes and the panel edge
    task automatic send_directed();
        int s;
        int edge_pos;
        s        = cur.scale;
        edge_pos = (cur.orient == ORIENT_CCW) ? cur.ph : cur.pw;
        send_item(pack_rect(0, 0, 0, 0, 0, 0));
        send_item(pack_rect(4095, 4095, 4095, 4095, 16383, 16383));
        send_item(pack_rect(20, 45, 10, 30, 0, 0));
        send_item(pack_rect(10, 30, 20, 45, 10*s - 1, 15*s - 1));
        send_item(pack_rect(10, 30, 20, 45, 10*s, 0));
        send_item(pack_rect(10, 30, 20, 45, 0, 15*s));
        send_item(pack_rect(4095, 4095, 0, 0, 0, 0));
        send_item(pack_rect(0, 0, 4095, 4095, 16383, 16383));
        send_item(pack_rect(12'hAAA, 12'h555, 12'h555, 12'hAAA, 14'h2AAA, 14'h1555));
        // last pixel on the panel, then the first one off it
        if (cur.orient == ORIENT_CCW) begin
            send_item(pack_rect(0, 0, 4095, 4095, edge_pos - 1, 0));
            send_item(pack_rect(0, 0, 4095, 4095, edge_pos, 0));
        end else begin
            send_item(pack_rect(0, 0, 4095, 4095, 0, edge_pos - 1));
            send_item(pack_rect(0, 0, 4095, 4095, 0, edge_pos));
        end
    endtask

    // Mostly in-range pixels of random rectangles, some at the span edge, some noise
    task automatic send_random_blit();
        int kind, w, h, lo_x, lo_y, sw, sh, col, row, x1, x2, y1, y2;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            send_item(pack_rect($urandom_range(0, 4095), $urandom_range(0, 4095),
                                $urandom_range(0, 4095), $urandom_range(0, 4095),
                                $urandom_range(0, 16383), $urandom_range(0, 16383)));
        end else begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 16);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 16);
            lo_x = $urandom_range(0, cur.corner_lim);
            lo_y = $urandom_range(0, cur.corner_lim);
            if (lo_x + w > 4095) lo_x = 4095 - w;
            if (lo_y + h > 4095) lo_y = 4095 - h;
            sw = w * cur.scale;
            sh = h * cur.scale;
            col = (sw == 0) ? $urandom_range(0, 3) : $urandom_range(0, sw - 1);
            row = (sh == 0) ? $urandom_range(0, 3) : $urandom_range(0, sh - 1);
            // land exactly on the span edge now and then
            if (kind < 22) begin
                if ($urandom_range(0, 1)) col = sw;
                else row = sh;
            end
            if (col > 16383) col = 16383;
            if (row > 16383) row = 16383;
            // corners in either order
            if ($urandom_range(0, 1)) begin
                x1 = lo_x; x2 = lo_x + w;
            end else begin
                x1 = lo_x + w; x2 = lo_x;
            end
            if ($urandom_range(0, 1)) begin
                y1 = lo_y; y2 = lo_y + h;
            end else begin
                y1 = lo_y + h; y2 = lo_y;
            end
            send_item(pack_rect(x1, y1, x2, y2, col, row));
        end
    endtask

    initial begin : stimulus
        blit_setup_t setups[9];
        setups[0] = '{ORIENT_CCW,    2, 4,  1024,  8192,  4096,  4096, 1800};
        setups[1] = '{ORIENT_CW,     4, 2, 16383, 65535, 10000, 16384, 2400};
        setups[2] = '{ORIENT_NORMAL, 3, 3,  5000, 12000, 16384,   100, 4095};
        setups[3] = '{ORIENT_NORMAL, 1, 4,     0,     0,     1,     1, 4095};
        setups[4] = '{ORIENT_RSVD,   2, 7,   777,  3333,  1000,  1000, 4095};
        setups[5] = '{ORIENT_CCW,    7, 0, 16383, 65535, 32767, 32767, 4095};
        setups[6] = '{ORIENT_CW,     1, 4,   300,   600,   200,   200,  150};
        setups[7] = '{ORIENT_CCW,    0, 5,   123,   456,    50, 16384,  100};
        setups[8] = '{ORIENT_CW,     5, 6,  9999, 40000,     0,   300, 1000};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: plain copy at unit scale
        send_item(pack_rect(3, 4, 9, 12, 0, 0));
        send_item(pack_rect(9, 12, 3, 4, 5, 7));
        send_item(pack_rect(0, 0, 4095, 4095, 16383, 16383));

        for (int p = 0; p < 9; p++) begin
            drain_results();
            load_setup(setups[p]);
            steady = (p == 2);
            if (p < 2) send_directed();
            for (int n = 0; n < 167; n++) begin
                if (p == 0 && n == 80) drain_results();
                send_random_blit();
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("scaled_rotated_blit_address_gen_unit test passed");
        else
            $display("scaled_rotated_blit_address_gen_unit test failed");
        $finish;
    end

endmodule
